// ===== rtl/cpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types and constants for the color patch chart generator.
// ----------------------------------------------------------------------------
package cpc_pkg;

    localparam int POS_W       = 14;   // pixel position counters
    localparam int SIZE_W      = 10;   // block_size / blank_size registers
    localparam int COLOR_W     = 8;    // one color component
    localparam int IDX_W       = 3;    // patch index on one axis
    localparam int NUM_COLORS  = 24;
    localparam int COLOR_IDX_W = $clog2(NUM_COLORS);
    localparam int CFG_IDX_W   = 2;

    localparam logic [SIZE_W-1:0] BLOCK_SIZE_RESET = SIZE_W'(200);
    localparam logic [SIZE_W-1:0] BLANK_SIZE_RESET = SIZE_W'(50);

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_SIZE = 2'd1;

    localparam logic [3*COLOR_W-1:0] BLACK = '0;

    localparam logic [3*COLOR_W-1:0] REF_COLORS [NUM_COLORS] = '{
        24'h735244, 24'hC29682, 24'h627A9D, 24'h576C43, 24'h8580B1, 24'h67BDAA,
        24'hD67E2C, 24'h505BA6, 24'hC15A63, 24'h5E3C6C, 24'h9DBC40, 24'hE0A32E,
        24'h383D96, 24'h469449, 24'hAF363C, 24'hE7C71F, 24'hBB5695, 24'h0885A1,
        24'hF3F3F2, 24'hC8C8C8, 24'hA0A0A0, 24'h7A7A79, 24'h555555, 24'h343434
    };

    // where one coordinate falls on its axis
    typedef struct packed {
        logic             hit;    // inside a patch
        logic [IDX_W-1:0] index;  // patch index, valid when hit
        logic             last;   // last pixel on this axis (or past it)
    } axis_loc_t;

endpackage

// ===== rtl/cpc_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_axis
// Locates one coordinate on an axis of N patches: patch hit, patch index and
// end-of-axis flag. Patch spans are compared in parallel, one lane per patch.
// ----------------------------------------------------------------------------
module cpc_axis
    import cpc_pkg::*;
#(
    parameter int N = 6
)
(
    input  logic [SIZE_W-1:0] block_size,
    input  logic [SIZE_W-1:0] blank_size,
    input  logic [POS_W-1:0]  pos,
    output axis_loc_t         loc
);

    // axis length never exceeds 1023 * (2N + 1)
    localparam int LEN_W = $clog2(((1 << SIZE_W) - 1) * (2 * N + 1) + 1);
    localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

    logic [LEN_W-1:0] len;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] len_ext;

    assign len = LEN_W'(block_size) * LEN_W'(N) + LEN_W'(blank_size) * LEN_W'(N + 1);
    assign pos_ext = CMP_W'(pos);
    assign len_ext = CMP_W'(len);

    always_comb
    begin
        logic [SIZE_W:0]  period;
        logic [CMP_W-1:0] span_lo;
        logic [CMP_W-1:0] span_hi;
        period    = (SIZE_W + 1)'(block_size) + (SIZE_W + 1)'(blank_size);
        loc.hit   = 1'b0;
        loc.index = '0;
        // empty axis counts as one pixel long
        loc.last  = (len_ext == '0) || (pos_ext >= len_ext - CMP_W'(1));
        for (int c = 0; c < N; c++)
        begin
            span_lo = CMP_W'(blank_size) + CMP_W'(c) * CMP_W'(period);
            span_hi = span_lo + CMP_W'(block_size);
            // spans are disjoint; zero block size gives empty spans
            if (pos_ext >= span_lo && pos_ext < span_hi)
            begin
                loc.hit   = 1'b1;
                loc.index = IDX_W'(c);
            end
        end
    end

endmodule

// ===== rtl/color_patch_chart_pattern_generator.sv =====
`timescale 1ns / 1ps
// An accepted input beat reaches the output on the next cycle.
// Throughput: one pixel per clock unless stalled; position counters
// and cpc_axis patch compare lanes settle within the single stage.
// Input is stalled only while an output beat is held by out_stall.
// Reset (rst_n low, async): position at top-left, output empty,
// block_size = 200, blank_size = 50.
// ----------------------------------------------------------------------------
// color_patch_chart_pattern_generator
// Raster-order test chart: a grid of reference color patches on black,
// with end-of-line and end-of-frame flags on every pixel.
// ----------------------------------------------------------------------------
module color_patch_chart_pattern_generator
    import cpc_pkg::*;
#(
    parameter int PATCH_ROWS    = 4,
    parameter int PATCH_COLUMNS = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 frame_restart,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [COLOR_W-1:0]   red,
    output logic [COLOR_W-1:0]   green,
    output logic [COLOR_W-1:0]   blue,
    output logic                 end_of_line,
    output logic                 end_of_frame
);

    logic [SIZE_W-1:0]    block_size_reg;
    logic [SIZE_W-1:0]    blank_size_reg;
    logic [POS_W-1:0]     col_reg, col_next;
    logic [POS_W-1:0]     row_reg, row_next;
    logic                 out_valid_reg;
    logic [3*COLOR_W-1:0] color_reg, color_next;
    logic                 eol_reg, eof_reg;

    logic                 accept;
    logic [POS_W-1:0]     cur_col, cur_row;
    axis_loc_t            x_loc, y_loc;
    logic                 eof_now;
    logic [COLOR_IDX_W-1:0] color_idx;

    // output register can take a new beat when empty or being drained
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= BLOCK_SIZE_RESET;
            blank_size_reg <= BLANK_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BLOCK_SIZE: block_size_reg <= cfg_data;
                CFG_BLANK_SIZE: blank_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cur_col = frame_restart ? '0 : col_reg;
    assign cur_row = frame_restart ? '0 : row_reg;

    cpc_axis #(.N(PATCH_COLUMNS)) u_x_axis
    (
        .block_size (block_size_reg),
        .blank_size (blank_size_reg),
        .pos        (cur_col),
        .loc        (x_loc)
    );

    cpc_axis #(.N(PATCH_ROWS)) u_y_axis
    (
        .block_size (block_size_reg),
        .blank_size (blank_size_reg),
        .pos        (cur_row),
        .loc        (y_loc)
    );

    assign eof_now   = x_loc.last && y_loc.last;
    assign color_idx = COLOR_IDX_W'(y_loc.index) * COLOR_IDX_W'(PATCH_COLUMNS)
                     + COLOR_IDX_W'(x_loc.index);

    always_comb
    begin
        color_next = (x_loc.hit && y_loc.hit) ? REF_COLORS[color_idx] : BLACK;
        if (eof_now)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (x_loc.last)
        begin
            col_next = '0;
            row_next = cur_row + POS_W'(1);
        end
        else
        begin
            col_next = cur_col + POS_W'(1);
            row_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            color_reg <= color_next;
            eol_reg   <= x_loc.last;
            eof_reg   <= eof_now;
        end
    end

    assign out_valid    = out_valid_reg;
    assign red          = color_reg[3*COLOR_W-1:2*COLOR_W];
    assign green        = color_reg[2*COLOR_W-1:COLOR_W];
    assign blue         = color_reg[COLOR_W-1:0];
    assign end_of_line  = eol_reg;
    assign end_of_frame = eof_reg;

endmodule

// ===== rtl/cpc_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_check
// Port-level checks for the color patch chart generator, bound to the top.
// ----------------------------------------------------------------------------
module cpc_check
    import cpc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [COLOR_W-1:0] red,
    input logic [COLOR_W-1:0] green,
    input logic [COLOR_W-1:0] blue,
    input logic               end_of_line,
    input logic               end_of_frame
);

    // held beat stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped while stalled");

    // held beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(red) && $stable(green) && $stable(blue)
            && $stable(end_of_line) && $stable(end_of_frame))
        else $error("output payload changed while stalled");

    // every accepted input beat shows up on the next cycle
    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted beat produced no output");

    // frame ends only on a line end
    a_eof_eol: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!end_of_frame || end_of_line))
        else $error("end_of_frame without end_of_line");

    // input backs up only behind a held output beat
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

endmodule

bind color_patch_chart_pattern_generator cpc_check u_cpc_check
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .end_of_line  (end_of_line),
    .end_of_frame (end_of_frame)
);
